@@ src/pds_pkg.sv @@
// shared types and constants for the pll divider search block
package pds_pkg;

  // field widths
  localparam int unsigned CLK_W   = 20;
  localparam int unsigned ACH_W   = 24;
  localparam int unsigned NUM_W   = 28;
  localparam int unsigned MUL_B_W = 7;

  // search limits
  localparam logic [2:0] IN_DIV_MIN  = 3'd1;
  localparam logic [2:0] IN_DIV_MAX  = 3'd7;
  localparam logic [6:0] MULT_MIN    = 7'd10;
  localparam logic [6:0] MULT_MAX    = 7'd125;
  localparam logic [1:0] OUT_IDX_MAX = 2'd3;
  localparam logic [NUM_W-1:0] START_DELTA = 28'd1000000;

  // register reset values and indexes
  localparam logic [CLK_W-1:0] RESET_LANE_MIN = 20'd31250;
  localparam logic [CLK_W-1:0] RESET_LANE_MAX = 20'd500000;
  localparam logic [1:0] REG_LANE_MIN = 2'd0;
  localparam logic [1:0] REG_LANE_MAX = 2'd1;

  typedef struct packed {
    logic [CLK_W-1:0] ref_clock_khz;
    logic [CLK_W-1:0] target_clock_khz;
  } in_word_t;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [2:0]       input_divider;
    logic [6:0]       loop_multiplier;
    logic [3:0]       output_divider;
    logic [ACH_W-1:0] achieved_khz;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LO,
    ST_LO_W,
    ST_HI,
    ST_HI_W,
    ST_N,
    ST_N_W,
    ST_G,
    ST_G_W,
    ST_FIN
  } state_t;

endpackage

@@ src/pds_divider.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module pds_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pds_pkg::NUM_W-1:0]   num,
  input  logic [pds_pkg::CLK_W-1:0]   den,
  output logic                        done,
  output logic [pds_pkg::NUM_W-1:0]   quot
);

  logic [pds_pkg::NUM_W-1:0] num_r, num_nxt;
  logic [pds_pkg::CLK_W-1:0] rem_r, rem_nxt;
  logic [pds_pkg::CLK_W-1:0] den_r;
  logic [4:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [pds_pkg::CLK_W:0]   trial;
  logic [pds_pkg::CLK_W:0]   diff;

  // one restoring step
  always_comb begin
    trial    = {rem_r, num_r[pds_pkg::NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = 5'(pds_pkg::NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[pds_pkg::CLK_W-1:0];
        num_nxt = {num_r[pds_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[pds_pkg::CLK_W-1:0];
        num_nxt = {num_r[pds_pkg::NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

@@ src/pll_divider_search.sv @@
// top level of the pll divider search block
// Takes one word at a time. A word with a zero clock goes from idle straight to
// the finish state, and its result moves to the output register once that is
// free. Otherwise every division goes through one shared bit-serial divider:
// two divisions per input divider for the multiplier window, and up to two per
// output divider (nearest multiplier, then achieved clock), so a full search
// covers seven input dividers, and stops early when the window floor ends the
// search or an exact match is hit. The next word is accepted as soon as the
// result has moved to the output register.
module pll_divider_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pds_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pds_pkg::out_word_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [pds_pkg::CLK_W-1:0]    cfg_data
);

  pds_pkg::state_t state_r, state_nxt;

  logic [pds_pkg::CLK_W-1:0] lane_min_r, lane_max_r;
  logic [pds_pkg::CLK_W-1:0] ref_r, tgt_r;
  logic                      zero_r, zero_nxt;
  logic [2:0]                i_r, i_nxt;
  logic [1:0]                oidx_r, oidx_nxt;
  logic [6:0]                nlo_r, nlo_nxt;
  logic [6:0]                nhi_r, nhi_nxt;
  logic [6:0]                n_r, n_nxt;
  logic                      found_r, found_nxt;
  logic [2:0]                best_i_r, best_i_nxt;
  logic [6:0]                best_n_r, best_n_nxt;
  logic [3:0]                best_o_r, best_o_nxt;
  logic [pds_pkg::ACH_W-1:0] best_got_r, best_got_nxt;
  logic [pds_pkg::NUM_W-1:0] best_dl_r, best_dl_nxt;
  logic                      out_valid_r, out_valid_nxt;
  pds_pkg::out_word_t        out_r, out_nxt;

  logic                      div_start;
  logic [pds_pkg::NUM_W-1:0] div_num;
  logic [pds_pkg::CLK_W-1:0] div_den;
  logic                      div_done;
  logic [pds_pkg::NUM_W-1:0] div_q;

  logic [pds_pkg::CLK_W-1:0]   mul_a;
  logic [pds_pkg::MUL_B_W-1:0] mul_b;
  logic [26:0]                 prod;
  logic [5:0]                  io;
  logic [pds_pkg::NUM_W-1:0]   delta;
  logic                        accept;
  logic                        out_free;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_min_r <= pds_pkg::RESET_LANE_MIN;
      lane_max_r <= pds_pkg::RESET_LANE_MAX;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pds_pkg::REG_LANE_MIN) begin
        lane_min_r <= cfg_data;
      end else if (cfg_index == pds_pkg::REG_LANE_MAX) begin
        lane_max_r <= cfg_data;
      end
    end
  end

  // shared multiplier and divider operands
  assign io = 6'({3'b0, i_r} << oidx_r);
  assign prod = mul_a * mul_b;
  always_comb begin
    mul_a     = ref_r;
    mul_b     = {4'b0, i_r};
    div_num   = '0;
    div_den   = ref_r;
    div_start = 1'b0;
    case (state_r)
      pds_pkg::ST_LO: begin
        mul_a     = lane_min_r;
        div_num   = {prod[24:0], 3'b000};
        div_start = 1'b1;
      end
      pds_pkg::ST_HI: begin
        mul_a     = lane_max_r;
        div_num   = {1'b0, prod};
        div_start = 1'b1;
      end
      pds_pkg::ST_N: begin
        mul_a     = tgt_r;
        div_num   = 28'({5'b0, prod[22:0]} << oidx_r) + 28'(ref_r >> 1);
        div_start = 1'b1;
      end
      pds_pkg::ST_G: begin
        mul_a     = ref_r;
        mul_b     = n_r;
        div_num   = {1'b0, prod} + 28'(io >> 1);
        div_den   = 20'(io);
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pds_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign delta = (div_q > {8'b0, tgt_r}) ? div_q - {8'b0, tgt_r}
                                         : {8'b0, tgt_r} - div_q;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != pds_pkg::ST_IDLE);

  // search sequencer
  always_comb begin
    state_nxt     = state_r;
    zero_nxt      = zero_r;
    i_nxt         = i_r;
    oidx_nxt      = oidx_r;
    nlo_nxt       = nlo_r;
    nhi_nxt       = nhi_r;
    n_nxt         = n_r;
    found_nxt     = found_r;
    best_i_nxt    = best_i_r;
    best_n_nxt    = best_n_r;
    best_o_nxt    = best_o_r;
    best_got_nxt  = best_got_r;
    best_dl_nxt   = best_dl_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      pds_pkg::ST_IDLE: begin
        if (accept) begin
          zero_nxt     = (in_data.ref_clock_khz == '0) ||
                         (in_data.target_clock_khz == '0);
          i_nxt        = pds_pkg::IN_DIV_MIN;
          found_nxt    = 1'b0;
          best_i_nxt   = '0;
          best_n_nxt   = '0;
          best_o_nxt   = '0;
          best_got_nxt = '0;
          best_dl_nxt  = pds_pkg::START_DELTA;
          state_nxt    = zero_nxt ? pds_pkg::ST_FIN : pds_pkg::ST_LO;
        end
      end
      pds_pkg::ST_LO: state_nxt = pds_pkg::ST_LO_W;
      pds_pkg::ST_LO_W: begin
        if (div_done) begin
          if (div_q >= 28'(pds_pkg::MULT_MAX - 7'd1)) begin
            state_nxt = pds_pkg::ST_FIN;
          end else begin
            nlo_nxt   = (div_q < 28'(pds_pkg::MULT_MIN - 7'd1)) ? pds_pkg::MULT_MIN
                                                               : div_q[6:0] + 7'd1;
            state_nxt = pds_pkg::ST_HI;
          end
        end
      end
      pds_pkg::ST_HI: state_nxt = pds_pkg::ST_HI_W;
      pds_pkg::ST_HI_W: begin
        if (div_done) begin
          nhi_nxt   = (div_q > 28'(pds_pkg::MULT_MAX)) ? pds_pkg::MULT_MAX : div_q[6:0];
          oidx_nxt  = '0;
          state_nxt = pds_pkg::ST_N;
        end
      end
      pds_pkg::ST_N: state_nxt = pds_pkg::ST_N_W;
      pds_pkg::ST_N_W: begin
        if (div_done) begin
          n_nxt = div_q[6:0];
          if (div_q < 28'(nlo_r) || div_q > 28'(nhi_r)) begin
            // outside the vco window, next output divider, or next input divider after the last one
            if (oidx_r == pds_pkg::OUT_IDX_MAX) begin
              i_nxt     = i_r + 3'd1;
              state_nxt = (i_r == pds_pkg::IN_DIV_MAX) ? pds_pkg::ST_FIN : pds_pkg::ST_LO;
            end else begin
              oidx_nxt  = oidx_r + 2'd1;
              state_nxt = pds_pkg::ST_N;
            end
          end else begin
            state_nxt = pds_pkg::ST_G;
          end
        end
      end
      pds_pkg::ST_G: state_nxt = pds_pkg::ST_G_W;
      pds_pkg::ST_G_W: begin
        if (div_done) begin
          if (delta < best_dl_r) begin
            found_nxt    = 1'b1;
            best_i_nxt   = i_r;
            best_n_nxt   = n_r;
            best_o_nxt   = 4'b0001 << oidx_r;
            best_got_nxt = div_q[pds_pkg::ACH_W-1:0];
            best_dl_nxt  = delta;
          end
          if (delta == '0) begin
            state_nxt = pds_pkg::ST_FIN;
          end else if (oidx_r == pds_pkg::OUT_IDX_MAX) begin
            i_nxt     = i_r + 3'd1;
            state_nxt = (i_r == pds_pkg::IN_DIV_MAX) ? pds_pkg::ST_FIN : pds_pkg::ST_LO;
          end else begin
            oidx_nxt  = oidx_r + 2'd1;
            state_nxt = pds_pkg::ST_N;
          end
        end
      end
      pds_pkg::ST_FIN: begin
        if (out_free) begin
          out_nxt.status          = zero_r;
          out_nxt.found           = found_r;
          out_nxt.input_divider   = best_i_r;
          out_nxt.loop_multiplier = best_n_r;
          out_nxt.output_divider  = best_o_r;
          out_nxt.achieved_khz    = best_got_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = pds_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pds_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pds_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      ref_r <= in_data.ref_clock_khz;
      tgt_r <= in_data.target_clock_khz;
    end
    zero_r     <= zero_nxt;
    i_r        <= i_nxt;
    oidx_r     <= oidx_nxt;
    nlo_r      <= nlo_nxt;
    nhi_r      <= nhi_nxt;
    n_r        <= n_nxt;
    found_r    <= found_nxt;
    best_i_r   <= best_i_nxt;
    best_n_r   <= best_n_nxt;
    best_o_r   <= best_o_nxt;
    best_got_r <= best_got_nxt;
    best_dl_r  <= best_dl_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a zero clock never reports a setting
  a_zero_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> !out_data.found && out_data.achieved_khz == '0)
    else $error("zero clock result carries a setting");

  // a found setting has its multiplier inside the loop range
  a_mult_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |->
      out_data.loop_multiplier >= pds_pkg::MULT_MIN &&
      out_data.loop_multiplier <= pds_pkg::MULT_MAX)
    else $error("multiplier out of range");

  // a found setting uses a power of two output divider
  a_odiv_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> $onehot(out_data.output_divider))
    else $error("output divider not a power of two");

endmodule
